@@ rtl/core/sitda_pkg.sv @@
package sitda_pkg;

    // Width of the binary magnitude shifted into the BCD row
    localparam int BIN_BITS   = 32;
    localparam int BIT_CNT_W  = $clog2(BIN_BITS);

    // Ten decimal digits cover 2**31
    localparam int NUM_DIGITS = 10;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam int CHAR_W     = 6;
    localparam int BCD_W      = 4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(BIN_BITS - 1);
    localparam logic [DIG_CNT_W-1:0] DIG_CNT_FULL = DIG_CNT_W'(NUM_DIGITS);
    localparam logic [DIG_CNT_W-1:0] DIG_CNT_ONE  = DIG_CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    // Control word broadcast to every cell of the row
    typedef struct packed {
        logic clear;
        logic bin_shift;
        logic dig_shift;
    } chain_ctl_t;

endpackage

@@ rtl/core/sitda_cell.sv @@
module sitda_cell
    import sitda_pkg::*;
(
    input  logic             clk,
    input  chain_ctl_t       ctl,
    input  logic             bit_in,
    input  logic [BCD_W-1:0] digit_in,
    output logic             bit_out,
    output logic [BCD_W-1:0] digit
);

    logic [BCD_W-1:0] digit_reg;
    logic [BCD_W-1:0] digit_next;
    logic [BCD_W-1:0] adj;

    // Add 3 before the shift so a digit that reaches ten or more carries out
    assign adj     = (digit_reg >= BCD_W'(5)) ? digit_reg + BCD_W'(3) : digit_reg;
    assign bit_out = adj[BCD_W-1];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.bin_shift)
        begin
            digit_next = {adj[BCD_W-2:0], bit_in};
        end
        else if (ctl.dig_shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

@@ rtl/core/sitda_chain.sv @@
module sitda_chain
    import sitda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_ctl_t       ctl,
    input  logic             bit_in,
    output logic [BCD_W-1:0] top_digit
);

    logic [BCD_W-1:0] digits [NUM_DIGITS];
    logic             carry  [NUM_DIGITS];

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            sitda_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .bit_in   (bit_in),
                .digit_in ('0),
                .bit_out  (carry[i]),
                .digit    (digits[i])
            );
        end
        else
        begin : g_rest
            sitda_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .bit_in   (carry[i-1]),
                .digit_in (digits[i-1]),
                .bit_out  (carry[i]),
                .digit    (digits[i])
            );
        end
    end

    assign top_digit = digits[NUM_DIGITS-1];

    a_ctl_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.clear, ctl.bin_shift, ctl.dig_shift}))
        else $error("row control has more than one action");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.bin_shift |-> !carry[NUM_DIGITS-1])
        else $error("BCD row overflowed its top digit");

    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dig_shift |=> (digits[0] == '0))
        else $error("bottom digit not zero-filled on digit shift");

endmodule

@@ rtl/core/signed_int_to_decimal_ascii_core.sv @@
// Flow: an accepted word's magnitude is shifted bit by bit into the BCD row (double
//   dabble), then leading zeros are dropped before the sign and digits are sent.
// A new word is accepted only in idle, after the last character of the previous
//   word has been loaded into the output register.
// Reset: rst_n, asynchronous and active low, returns the control to idle and
//   drops any pending output word; digit cells hold no reset.
module signed_int_to_decimal_ascii_core
    import sitda_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     value_valid,
    output logic                     value_stall,
    input  logic signed [BIN_BITS-1:0] value,
    output logic                     character_valid,
    input  logic                     character_stall,
    output logic [CHAR_W-1:0]        character,
    output logic                     last
);

    state_t                 state_reg;
    state_t                 state_next;
    logic [BIN_BITS-1:0]    mag_reg;
    logic [BIN_BITS-1:0]    mag_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg;
    logic [DIG_CNT_W-1:0]   dig_cnt_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   last_reg;
    logic                   last_next;

    logic [BIN_BITS-1:0]    raw;
    logic                   accept;
    logic                   slot_free;
    logic                   load;
    logic                   skip_done;
    chain_ctl_t             ctl;
    logic [BCD_W-1:0]       top_digit;

    // The output register frees its slot when empty or when the word leaves
    assign slot_free = !out_valid_reg || !character_stall;
    assign raw       = value;
    assign accept    = value_valid && !value_stall;

    // Leading zeros are dropped until a nonzero digit or the units digit is on top
    assign skip_done = (top_digit != '0) || (dig_cnt_reg == DIG_CNT_ONE);

    // Row of BCD cells: binary magnitude enters at the bottom, digits leave at the top
    sitda_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .bit_in    (mag_reg[BIN_BITS-1]),
        .top_digit (top_digit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == BIT_CNT_LAST)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (skip_done)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free && (dig_cnt_reg == DIG_CNT_ONE))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and row control for the current state
    always_comb
    begin
        value_stall   = 1'b1;
        ctl           = '0;
        load          = 1'b0;
        mag_next      = mag_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        neg_next      = neg_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                value_stall = 1'b0;
                if (value_valid)
                begin
                    // Two's complement magnitude; the most negative value maps to itself
                    neg_next     = raw[BIN_BITS-1];
                    mag_next     = raw[BIN_BITS-1] ? (~raw + BIN_BITS'(1)) : raw;
                    bit_cnt_next = '0;
                    ctl.clear    = 1'b1;
                end
            end
            ST_CONV:
            begin
                // Advance one magnitude bit into the row
                ctl.bin_shift = 1'b1;
                mag_next      = {mag_reg[BIN_BITS-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_LAST)
                begin
                    dig_cnt_next = DIG_CNT_FULL;
                end
            end
            ST_SKIP:
            begin
                if (!skip_done)
                begin
                    // Drop a leading zero
                    ctl.dig_shift = 1'b1;
                    dig_cnt_next  = dig_cnt_reg - DIG_CNT_W'(1);
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    char_next = CHAR_MINUS;
                    last_next = 1'b0;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    char_next     = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next     = (dig_cnt_reg == DIG_CNT_ONE);
                    ctl.dig_shift = 1'b1;
                    dig_cnt_next  = dig_cnt_reg - DIG_CNT_W'(1);
                end
            end
            default:
            begin
                value_stall = 1'b1;
            end
        endcase
    end

    // Output word register: hold while stalled, clear once taken
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!character_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign character_valid = out_valid_reg;
    assign character       = char_reg;
    assign last            = last_reg;

    a_conv_to_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && bit_cnt_reg == BIT_CNT_LAST) |=> (state_reg == ST_SKIP))
        else $error("conversion did not end after the last magnitude bit");

    a_digit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (dig_cnt_reg != '0))
        else $error("digit phase with no digits left");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (top_digit <= BCD_W'(9)))
        else $error("top cell holds a non-decimal digit");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CONV && bit_cnt_reg == '0))
        else $error("accepted word did not start conversion");

endmodule
